// ===== src/assert_macros.svh =====
// Shared assertion macros for the heap queue checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while the synchronous reset is low.
`define BHQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("heap queue check failed");

// Clocked check that also holds during reset.
`define BHQ_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("heap queue check failed");

`endif

// ===== src/bhq_pkg.sv =====
`default_nettype none

package bhq_pkg;

    localparam int KEY_W        = 32;
    localparam int ID_W         = 16;
    localparam int CNT_OUT_W    = 9;
    localparam int CAPACITY_DEF = 256;

    typedef enum logic [0:0] {
        KIND_INSERT = 1'b0,
        KIND_POP    = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_kind             kind;
        logic [ID_W-1:0]   entry_id;
        logic [KEY_W-1:0]  entry_key;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]      popped_id;
        logic [KEY_W-1:0]     popped_key;
        logic                 popped_valid;
        t_status              status;
        logic [CNT_OUT_W-1:0] entry_count;
        logic [ID_W-1:0]      top_id;
        logic [KEY_W-1:0]     top_key;
        logic                 queue_empty;
    } t_out_item;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

// ===== src/bhq_ram.sv =====
`default_nettype none

module bhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/bhq_seq.sv =====
`default_nettype none

module bhq_seq import bhq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_item,
    output logic      o_idle,
    output logic      o_done,
    output t_out_item o_result,
    input  logic      i_res_free
);

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IW    = AW + 2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LAST,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_L,
        S_DN_R,
        S_DN_CMP,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [AW-1:0]     r_pos, n_pos;
    logic [AW-1:0]     r_child_pos, n_child_pos;
    t_entry            r_cur, n_cur;
    t_entry            r_child, n_child;
    t_entry            r_top, n_top;
    t_entry            r_popped, n_popped;
    logic              r_popped_valid, n_popped_valid;
    t_status           r_status, n_status;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    t_entry            mem_wdata;
    logic [AW-1:0]     mem_raddr;
    logic [ENTRY_W-1:0] mem_rdata;
    t_entry            rd_entry;

    logic [AW-1:0]     par_pos;
    logic [AW-1:0]     last_addr;
    logic [IW-1:0]     l_idx;
    logic [IW-1:0]     right_idx;
    logic [IW-1:0]     cnt_ext;
    logic [KEY_W-1:0]  cmp_a;
    logic [KEY_W-1:0]  cmp_b;
    logic              cmp_gt;
    logic              empty;

    bhq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_entry  = t_entry'(mem_rdata);
    assign par_pos   = (r_pos - AW'(1)) >> 1;
    assign last_addr = AW'(r_count - CNT_W'(1));
    assign l_idx     = {1'b0, r_pos, 1'b1};
    assign right_idx = l_idx + IW'(1);
    assign cnt_ext   = IW'(r_count);

    // shared key comparator: true when operand b is strictly greater
    always_comb begin
        unique case (r_state)
            S_UP_CMP: begin
                cmp_a = rd_entry.key;
                cmp_b = r_cur.key;
            end
            S_DN_R: begin
                cmp_a = r_child.key;
                cmp_b = rd_entry.key;
            end
            default: begin
                cmp_a = r_cur.key;
                cmp_b = r_child.key;
            end
        endcase
    end

    assign cmp_gt = cmp_b > cmp_a;

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_pos          = r_pos;
        n_child_pos    = r_child_pos;
        n_cur          = r_cur;
        n_child        = r_child;
        n_popped       = r_popped;
        n_popped_valid = r_popped_valid;
        n_status       = r_status;
        mem_we         = 1'b0;
        mem_waddr      = r_pos;
        mem_wdata      = r_cur;
        mem_raddr      = '0;

        unique case (r_state)
            S_IDLE: begin
                mem_raddr = last_addr;
                if (i_start) begin
                    n_popped_valid = 1'b0;
                    n_status       = STATUS_OK;
                    if (i_item.kind == KIND_INSERT) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_status = STATUS_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_cur.id  = i_item.entry_id;
                            n_cur.key = i_item.entry_key;
                            n_pos     = r_count[AW-1:0];
                            n_count   = r_count + CNT_W'(1);
                            n_state   = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = STATUS_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_popped       = r_top;
                            n_popped_valid = 1'b1;
                            n_count        = r_count - CNT_W'(1);
                            n_state        = (r_count == CNT_W'(1)) ? S_DONE : S_LAST;
                        end
                    end
                end
            end
            S_LAST: begin
                n_cur   = rd_entry;
                n_pos   = '0;
                n_state = S_DN_RD;
            end
            S_UP_RD: begin
                if (r_pos == '0) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    mem_raddr = par_pos;
                    n_state   = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                mem_we = 1'b1;
                if (cmp_gt) begin
                    mem_wdata = rd_entry;
                    n_pos     = par_pos;
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DN_RD: begin
                if (l_idx >= cnt_ext) begin
                    mem_we  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    mem_raddr = l_idx[AW-1:0];
                    n_state   = S_DN_L;
                end
            end
            S_DN_L: begin
                n_child     = rd_entry;
                n_child_pos = l_idx[AW-1:0];
                if (right_idx < cnt_ext) begin
                    mem_raddr = right_idx[AW-1:0];
                    n_state   = S_DN_R;
                end else begin
                    n_state = S_DN_CMP;
                end
            end
            S_DN_R: begin
                if (cmp_gt) begin
                    n_child     = rd_entry;
                    n_child_pos = right_idx[AW-1:0];
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                mem_we = 1'b1;
                if (cmp_gt) begin
                    mem_wdata = r_child;
                    n_pos     = r_child_pos;
                    n_state   = S_DN_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_top = (mem_we && (mem_waddr == '0)) ? mem_wdata : r_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_pos          <= n_pos;
        r_child_pos    <= n_child_pos;
        r_cur          <= n_cur;
        r_child        <= n_child;
        r_top          <= n_top;
        r_popped       <= n_popped;
        r_popped_valid <= n_popped_valid;
        r_status       <= n_status;
    end

    assign empty  = (r_count == '0);
    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);

    always_comb begin
        o_result              = '0;
        o_result.popped_valid = r_popped_valid;
        o_result.popped_id    = r_popped_valid ? r_popped.id : '0;
        o_result.popped_key   = r_popped_valid ? r_popped.key : '0;
        o_result.status       = r_status;
        o_result.entry_count  = CNT_OUT_W'(r_count);
        o_result.top_id       = empty ? '0 : r_top.id;
        o_result.top_key      = empty ? '0 : r_top.key;
        o_result.queue_empty  = empty;
    end

endmodule

`default_nettype wire

// ===== src/binary_max_heap_queue.sv =====
// Channel  | Valid        | Ready        | Payload
// ---------+--------------+--------------+----------------------
// input    | i_in_valid   | o_in_ready   | i_in_data  (t_in_item)
// output   | o_out_valid  | i_out_ready  | o_out_data (t_out_item)
//
// Error (insert when full, pop when empty) and a pop that empties the queue end at once; an
// insert climbs from the new last slot past each smaller parent; other pops move the last entry
// to the root and sink it. All steps use one RAM read port and one shared key comparator.
// Reset: synchronous, active low; clears the count, the heap contents are not cleared.
// Stalls: a finished result waits in the output register while the next item is taken.
`default_nettype none

module binary_max_heap_queue import bhq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic      seq_idle;
    logic      seq_done;
    t_out_item seq_result;
    logic      res_free;
    logic      r_out_valid;
    t_out_item r_out_data;

    assign res_free = !r_out_valid || i_out_ready;

    bhq_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in_valid && seq_idle),
        .i_item     (i_in_data),
        .o_idle     (seq_idle),
        .o_done     (seq_done),
        .o_result   (seq_result),
        .i_res_free (res_free)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_done && res_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_done && res_free) begin
            r_out_data <= seq_result;
        end
    end

    assign o_in_ready  = seq_idle;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== src/bhq_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module bhq_checker import bhq_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      o_in_ready,
    input  logic      o_out_valid,
    input  logic      i_out_ready,
    input  t_out_item o_out_data
);

    logic [CNT_OUT_W-1:0] cap_cnt;

    assign cap_cnt = CNT_OUT_W'(CAPACITY);

    `BHQ_ASSERT(a_out_hold, i_clk, i_rst_n,
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
    `BHQ_ASSERT(a_busy_after_accept, i_clk, i_rst_n,
        (i_in_valid && o_in_ready) |=> !o_in_ready)
    `BHQ_ASSERT(a_empty_view, i_clk, i_rst_n,
        (o_out_valid && o_out_data.queue_empty) |-> ((o_out_data.entry_count == '0) &&
        (o_out_data.top_key == '0) && (o_out_data.top_id == '0)))
    `BHQ_ASSERT(a_full_reject, i_clk, i_rst_n,
        (o_out_valid && (o_out_data.status == STATUS_FULL)) |->
        ((o_out_data.entry_count == cap_cnt) && !o_out_data.popped_valid))
    `BHQ_ASSERT(a_pop_ok, i_clk, i_rst_n,
        (o_out_valid && o_out_data.popped_valid) |->
        ((o_out_data.status == STATUS_OK) && (o_out_data.entry_count != cap_cnt)))

endmodule

bind binary_max_heap_queue bhq_checker #(.CAPACITY(CAPACITY)) u_bhq_checker (.*);

`default_nettype wire
